// ===== hw/rtl/tsc_pkg.sv =====
// Shared types and constants for the touch swipe/tap classifier.
// Holds the configuration register map, reset values and event codes.
// No dependencies.
`default_nettype none

package tsc_pkg;

  // Configuration port geometry
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // Register indexes on the configuration port
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SWIPE_MIN_DISTANCE = 3'd0,
    REG_TAP_MAX_MS         = 3'd1,
    REG_BRIGHTNESS_STEP    = 3'd2,
    REG_BRIGHTNESS_MIN     = 3'd3,
    REG_BRIGHTNESS_MAX     = 3'd4
  } reg_idx_t;

  // Register reset values
  localparam logic [11:0] SWIPE_MIN_DISTANCE_RST = 12'd50;
  localparam logic [15:0] TAP_MAX_MS_RST         = 16'd500;
  localparam logic [6:0]  BRIGHTNESS_STEP_RST    = 7'd10;
  localparam logic [6:0]  BRIGHTNESS_MIN_RST     = 7'd10;
  localparam logic [6:0]  BRIGHTNESS_MAX_RST     = 7'd100;

  // Brightness held after reset
  localparam logic [6:0]  BRIGHTNESS_RST         = 7'd100;

  // Gesture event codes
  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_TAP      = 3'd1,
    EV_VOL_UP   = 3'd2,
    EV_VOL_DOWN = 3'd3,
    EV_BRIGHT   = 3'd4
  } gesture_t;

  // Current configuration, fanned out to the classifier
  typedef struct packed {
    logic [11:0] swipe_min_distance;
    logic [15:0] tap_max_ms;
    logic [6:0]  brightness_step;
    logic [6:0]  brightness_min;
    logic [6:0]  brightness_max;
  } cfg_t;

  // Decoded poll, apart from the coordinates
  typedef struct packed {
    logic        pressed;
    logic [31:0] time_ms;
  } poll_t;

endpackage

`default_nettype wire

// ===== hw/rtl/tsc_cfg.sv =====
// Configuration register bank for the touch classifier.
// Plain write port, no read-back. Depends on tsc_pkg.
`default_nettype none

module tsc_cfg (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_we,
  input  wire logic [tsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tsc_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output tsc_pkg::cfg_t                       cfg
);
  import tsc_pkg::*;

  cfg_t cfg_r;

  // Register writes; indexes past the map are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.swipe_min_distance <= SWIPE_MIN_DISTANCE_RST;
      cfg_r.tap_max_ms         <= TAP_MAX_MS_RST;
      cfg_r.brightness_step    <= BRIGHTNESS_STEP_RST;
      cfg_r.brightness_min     <= BRIGHTNESS_MIN_RST;
      cfg_r.brightness_max     <= BRIGHTNESS_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_SWIPE_MIN_DISTANCE: cfg_r.swipe_min_distance <= cfg_wdata[11:0];
        REG_TAP_MAX_MS:         cfg_r.tap_max_ms         <= cfg_wdata[15:0];
        REG_BRIGHTNESS_STEP:    cfg_r.brightness_step    <= cfg_wdata[6:0];
        REG_BRIGHTNESS_MIN:     cfg_r.brightness_min     <= cfg_wdata[6:0];
        REG_BRIGHTNESS_MAX:     cfg_r.brightness_max     <= cfg_wdata[6:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== hw/rtl/tsc_decode.sv =====
// Input stage: decodes the raw poll bytes and holds them in the input register.
// Depends on tsc_pkg.
`default_nettype none

module tsc_decode #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  // [7:0] status_byte, [15:8] x_high_byte, [23:16] x_low_byte,
  // [31:24] y_high_byte, [39:32] y_low_byte, [71:40] time_ms
  input  wire logic [71:0]           in_tdata,
  // [0] read_ok
  input  wire logic                  in_tuser,
  input  wire logic                  take,
  output logic                       s1_valid,
  output tsc_pkg::poll_t             s1_poll,
  output logic [COORD_BITS-1:0]      s1_x,
  output logic [COORD_BITS-1:0]      s1_y
);
  import tsc_pkg::*;

  logic                  valid_r;
  poll_t                 poll_r;
  logic [COORD_BITS-1:0] x_r;
  logic [COORD_BITS-1:0] y_r;

  logic                  accept;
  poll_t                 poll_nxt;
  logic [11:0]           x_raw;
  logic [11:0]           y_raw;

  // Free slot, or slot emptying this cycle
  assign in_tready = !valid_r || take;
  assign accept    = in_tvalid && in_tready;

  // Decode: failed read counts as no touch; coordinate is nibble:byte
  always_comb begin
    poll_nxt.pressed = in_tuser && (in_tdata[3:0] != 4'd0);
    poll_nxt.time_ms = in_tdata[71:40];
    x_raw            = {in_tdata[11:8], in_tdata[23:16]};
    y_raw            = {in_tdata[27:24], in_tdata[39:32]};
  end

  // Input register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (accept) begin
      valid_r <= 1'b1;
    end else if (take) begin
      valid_r <= 1'b0;
    end
  end

  // Input register payload
  always_ff @(posedge clk) begin
    if (accept) begin
      poll_r <= poll_nxt;
      x_r    <= COORD_BITS'(x_raw);
      y_r    <= COORD_BITS'(y_raw);
    end
  end

  assign s1_valid = valid_r;
  assign s1_poll  = poll_r;
  assign s1_x     = x_r;
  assign s1_y     = y_r;

endmodule

`default_nettype wire

// ===== hw/rtl/tsc_classify.sv =====
// Gesture classifier: press tracking state, swipe/tap decision, brightness
// and the result register. Depends on tsc_pkg.
`default_nettype none

module tsc_classify #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire tsc_pkg::cfg_t         cfg,
  input  wire logic                  s1_valid,
  input  wire tsc_pkg::poll_t        s1_poll,
  input  wire logic [COORD_BITS-1:0] s1_x,
  input  wire logic [COORD_BITS-1:0] s1_y,
  output logic                       take,
  output logic                       out_tvalid,
  input  wire logic                  out_tready,
  // [2:0] gesture_event, [9:3] brightness_level, [10] touch_active
  output logic [15:0]                out_tdata
);
  import tsc_pkg::*;

  // Compare width covers 3*|d| and the 12-bit threshold
  localparam int CMP_W = (COORD_BITS + 2 > 12) ? COORD_BITS + 2 : 12;

  // Press tracking state
  logic                  was_touched_r, was_touched_nxt;
  logic [COORD_BITS-1:0] start_x_r, start_x_nxt;
  logic [COORD_BITS-1:0] start_y_r, start_y_nxt;
  logic [31:0]           press_time_r, press_time_nxt;
  logic                  swipe_seen_r, swipe_seen_nxt;
  logic [6:0]            brightness_r, brightness_nxt;

  // Result register
  logic                  out_valid_r;
  gesture_t              ev_r, ev_nxt;
  logic [6:0]            level_r;
  logic                  active_r;

  // Motion terms
  logic signed [COORD_BITS:0] dx;
  logic signed [COORD_BITS:0] dy;
  logic [COORD_BITS-1:0]      ax_mag;
  logic [COORD_BITS-1:0]      ay_mag;
  logic [CMP_W-1:0]           ax;
  logic [CMP_W-1:0]           ay;
  logic [CMP_W-1:0]           ax_lim;
  logic [CMP_W-1:0]           ay_lim;
  logic [CMP_W-1:0]           thr;
  logic                       horiz;
  logic                       vert;
  logic signed [8:0]          b_sum;
  logic signed [8:0]          b_hi;
  logic signed [8:0]          b_clamp;
  logic [31:0]                held_ms;
  logic                       is_tap;

  // Item moves on when the result register is free or being drained
  assign take = s1_valid && (!out_valid_r || out_tready);

  // Signed travel from the start point and its 1.5x limits
  always_comb begin
    dx     = $signed({1'b0, s1_x}) - $signed({1'b0, start_x_r});
    dy     = $signed({1'b0, s1_y}) - $signed({1'b0, start_y_r});
    ax_mag = dx[COORD_BITS] ? COORD_BITS'(-dx) : COORD_BITS'(dx);
    ay_mag = dy[COORD_BITS] ? COORD_BITS'(-dy) : COORD_BITS'(dy);
    ax     = CMP_W'(ax_mag);
    ay     = CMP_W'(ay_mag);
    ax_lim = (ax + (ax << 1)) >> 1;
    ay_lim = (ay + (ay << 1)) >> 1;
    thr    = CMP_W'(cfg.swipe_min_distance);
    horiz  = (ax > thr) && (ax > ay_lim);
    vert   = (ay > thr) && (ay > ax_lim);
  end

  // Brightness step and clamp; lower limit wins when limits cross
  always_comb begin
    if (dy[COORD_BITS]) begin
      b_sum = $signed({2'b00, brightness_r}) + $signed({2'b00, cfg.brightness_step});
    end else begin
      b_sum = $signed({2'b00, brightness_r}) - $signed({2'b00, cfg.brightness_step});
    end
    b_hi    = (b_sum > $signed({2'b00, cfg.brightness_max})) ?
              $signed({2'b00, cfg.brightness_max}) : b_sum;
    b_clamp = (b_hi < $signed({2'b00, cfg.brightness_min})) ?
              $signed({2'b00, cfg.brightness_min}) : b_hi;
  end

  // Tap window, modulo 2^32
  assign held_ms = s1_poll.time_ms - press_time_r;
  assign is_tap  = !swipe_seen_r && (held_ms < {16'd0, cfg.tap_max_ms});

  // Next state and event
  always_comb begin
    was_touched_nxt = s1_poll.pressed;
    start_x_nxt     = start_x_r;
    start_y_nxt     = start_y_r;
    press_time_nxt  = press_time_r;
    swipe_seen_nxt  = swipe_seen_r;
    brightness_nxt  = brightness_r;
    ev_nxt          = EV_NONE;
    if (s1_poll.pressed && !was_touched_r) begin
      // press edge: latch start point
      start_x_nxt    = s1_x;
      start_y_nxt    = s1_y;
      press_time_nxt = s1_poll.time_ms;
      swipe_seen_nxt = 1'b0;
    end else if (s1_poll.pressed && !swipe_seen_r) begin
      // held: horizontal test first
      if (horiz) begin
        swipe_seen_nxt = 1'b1;
        ev_nxt         = (dx > 0) ? EV_VOL_UP : EV_VOL_DOWN;
      end else if (vert) begin
        swipe_seen_nxt = 1'b1;
        brightness_nxt = b_clamp[6:0];
        ev_nxt         = EV_BRIGHT;
      end
    end else if (!s1_poll.pressed && was_touched_r) begin
      // release edge
      if (is_tap) begin
        ev_nxt = EV_TAP;
      end
    end
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      was_touched_r <= 1'b0;
      start_x_r     <= '0;
      start_y_r     <= '0;
      press_time_r  <= '0;
      swipe_seen_r  <= 1'b0;
      brightness_r  <= BRIGHTNESS_RST;
    end else if (take) begin
      was_touched_r <= was_touched_nxt;
      start_x_r     <= start_x_nxt;
      start_y_r     <= start_y_nxt;
      press_time_r  <= press_time_nxt;
      swipe_seen_r  <= swipe_seen_nxt;
      brightness_r  <= brightness_nxt;
    end
  end

  // Result register control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (take) begin
      ev_r     <= ev_nxt;
      level_r  <= brightness_nxt;
      active_r <= s1_poll.pressed;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {5'd0, active_r, level_r, ev_r};

endmodule

`default_nettype wire

// ===== hw/rtl/touch_swipe_tap_classifier.sv =====
// Touch swipe/tap classifier, top level.
// Instantiates tsc_cfg, tsc_decode and tsc_classify; depends on tsc_pkg.
//
// Usage:
//   One input transfer is one poll of the touch controller: the five raw
//   report bytes and the timestamp on in_tdata, the read-ok flag on in_tuser.
//   Every poll gives exactly one output transfer carrying the gesture event,
//   the current brightness and the touch-active flag.
//   Configuration is written through cfg_we/cfg_index/cfg_wdata while idle.
//
// Timing:
//   A poll is held in the input register, is classified there and lands in
//   the result register once that register is free or being drained. One
//   poll per cycle is accepted while out_tready stays high; the classify path
//   between the input and result registers is combinational.
//
// Reset (rst_n low, synchronous): both registers empty, press tracking
// cleared, brightness 100, configuration back to its defaults.
// Stall: while out_tready is low the result holds; one further poll may sit
// in the input register, after which in_tready drops.
`default_nettype none

module touch_swipe_tap_classifier #(
  parameter int COORD_BITS = 12
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  // [7:0] status_byte, [15:8] x_high_byte, [23:16] x_low_byte,
  // [31:24] y_high_byte, [39:32] y_low_byte, [71:40] time_ms
  input  wire logic [71:0]                    in_tdata,
  // [0] read_ok
  input  wire logic                           in_tuser,
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  // [2:0] gesture_event, [9:3] brightness_level, [10] touch_active
  output logic [15:0]                         out_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [tsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [tsc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import tsc_pkg::*;

  cfg_t                  cfg;
  logic                  take;
  logic                  s1_valid;
  poll_t                 s1_poll;
  logic [COORD_BITS-1:0] s1_x;
  logic [COORD_BITS-1:0] s1_y;

  tsc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  tsc_decode #(
    .COORD_BITS (COORD_BITS)
  ) u_decode (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .take      (take),
    .s1_valid  (s1_valid),
    .s1_poll   (s1_poll),
    .s1_x      (s1_x),
    .s1_y      (s1_y)
  );

  tsc_classify #(
    .COORD_BITS (COORD_BITS)
  ) u_classify (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .s1_valid   (s1_valid),
    .s1_poll    (s1_poll),
    .s1_x       (s1_x),
    .s1_y       (s1_y),
    .take       (take),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench for touch_swipe_tap_classifier.
// Drives controller polls and predicts tap, volume and brightness events in step.
// Depends on tsc_pkg and the classifier RTL only.

module tb;

  localparam int COORD_MAX = 4095;

  // One poll as it travels on the input channel
  typedef struct packed {
    logic        read_ok;
    logic [7:0]  status;
    logic [7:0]  x_hi;
    logic [7:0]  x_lo;
    logic [7:0]  y_hi;
    logic [7:0]  y_lo;
    logic [31:0] stamp;
  } poll_frame_t;

  // One classifier result
  typedef struct packed {
    tsc_pkg::gesture_t ev;
    logic [6:0]        level;
    logic              active;
  } gesture_result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [71:0] in_tdata = '0;
  logic in_tuser = 1'b0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [15:0] out_tdata;
  logic cfg_we = 1'b0;
  logic [tsc_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [tsc_pkg::CFG_DATA_W-1:0] cfg_wdata = '0;

  touch_swipe_tap_classifier i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mirror of the classifier configuration and press tracking
  logic [11:0] m_swipe_min;
  logic [15:0] m_tap_max;
  logic [6:0]  m_step, m_lo, m_hi;
  logic        m_touched, m_swiped;
  logic [11:0] m_start_x, m_start_y;
  logic [31:0] m_press_t;
  logic [6:0]  m_level;

  gesture_result_t gesture_due[$];
  int mismatches = 0;
  int polls_sent = 0;
  int hold_cycles = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  function automatic void reset_model();
    m_swipe_min = tsc_pkg::SWIPE_MIN_DISTANCE_RST;
    m_tap_max   = tsc_pkg::TAP_MAX_MS_RST;
    m_step      = tsc_pkg::BRIGHTNESS_STEP_RST;
    m_lo        = tsc_pkg::BRIGHTNESS_MIN_RST;
    m_hi        = tsc_pkg::BRIGHTNESS_MAX_RST;
    m_touched   = 1'b0;
    m_swiped    = 1'b0;
    m_start_x   = '0;
    m_start_y   = '0;
    m_press_t   = '0;
    m_level     = tsc_pkg::BRIGHTNESS_RST;
  endfunction

  // Works out the event for one poll and advances the press tracking
  function automatic gesture_result_t classify_poll(input poll_frame_t p);
    gesture_result_t r;
    logic pressed;
    logic [11:0] px, py;
    logic [31:0] held;
    int dx, dy, ax, ay, lim, lvl;
    pressed = p.read_ok && (p.status[3:0] != 4'd0);
    px = {p.x_hi[3:0], p.x_lo};
    py = {p.y_hi[3:0], p.y_lo};
    r.ev = tsc_pkg::EV_NONE;
    if (pressed && !m_touched) begin
      // press edge: latch start point and time
      m_start_x = px;
      m_start_y = py;
      m_press_t = p.stamp;
      m_swiped  = 1'b0;
    end else if (pressed && !m_swiped) begin
      dx  = int'(px) - int'(m_start_x);
      dy  = int'(py) - int'(m_start_y);
      ax  = (dx < 0) ? -dx : dx;
      ay  = (dy < 0) ? -dy : dy;
      lim = int'(m_swipe_min);
      if (ax > lim && ax > (ay * 3) / 2) begin
        m_swiped = 1'b1;
        r.ev = (dx > 0) ? tsc_pkg::EV_VOL_UP : tsc_pkg::EV_VOL_DOWN;
      end else if (ay > lim && ay > (ax * 3) / 2) begin
        // upward swipe raises brightness; lower clamp applied last
        lvl = int'(m_level) + ((dy < 0) ? int'(m_step) : -int'(m_step));
        if (lvl > int'(m_hi)) lvl = int'(m_hi);
        if (lvl < int'(m_lo)) lvl = int'(m_lo);
        m_level  = lvl[6:0];
        m_swiped = 1'b1;
        r.ev = tsc_pkg::EV_BRIGHT;
      end
    end else if (!pressed && m_touched) begin
      held = p.stamp - m_press_t;
      if (!m_swiped && held < {16'd0, m_tap_max}) r.ev = tsc_pkg::EV_TAP;
    end
    m_touched = pressed;
    r.level   = m_level;
    r.active  = pressed;
    return r;
  endfunction

  // Predict on every accepted input transfer
  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready)
      gesture_due.push_back(classify_poll(poll_frame_t'({in_tuser, in_tdata[7:0],
        in_tdata[15:8], in_tdata[23:16], in_tdata[31:24], in_tdata[39:32],
        in_tdata[71:40]})));
  end

  // Compare every result transfer with the oldest prediction
  always @(posedge clk) begin
    gesture_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      if (gesture_due.size() == 0) begin
        $error("result transfer with nothing expected: tdata %h", out_tdata);
        mismatches++;
      end else begin
        want = gesture_due.pop_front();
        if (out_tdata[2:0] !== want.ev) begin
          $error("gesture_event: expected %0d, got %0d", want.ev, out_tdata[2:0]);
          mismatches++;
        end
        if (out_tdata[9:3] !== want.level) begin
          $error("brightness_level: expected %0d, got %0d", want.level, out_tdata[9:3]);
          mismatches++;
        end
        if (out_tdata[10] !== want.active) begin
          $error("touch_active: expected %0d, got %0d", want.active, out_tdata[10]);
          mismatches++;
        end
      end
    end
  end

  // Result side: random stalls, plus a long hold-off on request
  initial begin
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_cycles > 0) begin
        out_tready <= 1'b0;
        hold_cycles--;
      end else if (rx_idle && $urandom_range(0, 4) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(0, 8)) @(posedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // Offer one poll, with an optional gap first, and wait for its transfer
  task automatic send_poll(input poll_frame_t p);
    if (tx_idle && $urandom_range(0, 3) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_tdata  <= {p.stamp, p.y_lo, p.y_hi, p.x_lo, p.x_hi, p.status};
    in_tuser  <= p.read_ok;
    in_tvalid <= 1'b1;
    do @(posedge clk); while (!in_tready);
    polls_sent++;
  endtask

  // Poll with a touch at (x, y); unused upper nibbles carry junk
  function automatic poll_frame_t touch_at(input int x, input int y, input logic [31:0] t);
    poll_frame_t p;
    logic [31:0] rw;
    rw = $urandom;
    p.read_ok = 1'b1;
    p.status  = {rw[3:0], 4'($urandom_range(1, 15))};
    p.x_hi    = {rw[7:4], x[11:8]};
    p.x_lo    = x[7:0];
    p.y_hi    = {rw[11:8], y[11:8]};
    p.y_lo    = y[7:0];
    p.stamp   = t;
    return p;
  endfunction

  // Poll with no touch: either a failed read or a zero touch count
  function automatic poll_frame_t lift_at(input logic [31:0] t);
    poll_frame_t p;
    logic [31:0] rw;
    rw = $urandom;
    p.read_ok = rw[0];
    p.status  = rw[0] ? {rw[7:4], 4'h0} : rw[15:8];
    p.x_hi    = rw[23:16];
    p.x_lo    = rw[31:24];
    rw = $urandom;
    p.y_hi    = rw[7:0];
    p.y_lo    = rw[15:8];
    p.stamp   = t;
    return p;
  endfunction

  function automatic poll_frame_t noise_poll();
    poll_frame_t p;
    logic [31:0] rw;
    rw = $urandom;
    p.read_ok = rw[0];
    p.status  = rw[15:8];
    p.x_hi    = rw[23:16];
    p.x_lo    = rw[31:24];
    rw = $urandom;
    p.y_hi    = rw[7:0];
    p.y_lo    = rw[15:8];
    p.stamp   = $urandom;
    return p;
  endfunction

  function automatic int clip(input int v);
    return (v < 0) ? 0 : (v > COORD_MAX) ? COORD_MAX : v;
  endfunction

  // Motion offset: half the time near the current swipe threshold, else zero or anywhere in range
  function automatic int jitter();
    int span;
    span = int'(m_swipe_min) + 8;
    case ($urandom_range(0, 3))
      0:       return 0;
      1:       return int'($urandom_range(0, 2 * COORD_MAX)) - COORD_MAX;
      default: return int'($urandom_range(0, 2 * span)) - span;
    endcase
  endfunction

  // Press, a few moves, release after a short, borderline or random hold
  task automatic one_gesture();
    int x0, y0;
    logic [31:0] t, t_press;
    t  = ($urandom_range(0, 7) == 0) ? 32'hFFFF_FF00 + $urandom_range(0, 255) : $urandom;
    x0 = $urandom_range(0, COORD_MAX);
    y0 = $urandom_range(0, COORD_MAX);
    t_press = t;
    send_poll(touch_at(x0, y0, t));
    repeat ($urandom_range(0, 4)) begin
      t = t + $urandom_range(1, 100);
      send_poll(touch_at(clip(x0 + jitter()), clip(y0 + jitter()), t));
    end
    case ($urandom_range(0, 2))
      0:       t = t_press + $urandom_range(0, 2 * m_tap_max + 2);
      1:       t = t_press + m_tap_max - $urandom_range(0, 1);
      default: t = $urandom;
    endcase
    send_poll(lift_at(t));
  endtask

  task automatic run_gestures(input int n);
    int target;
    target = polls_sent + n;
    while (polls_sent < target) begin
      if ($urandom_range(0, 4) == 0)
        repeat ($urandom_range(1, 3)) send_poll(noise_poll());
      else
        one_gesture();
    end
  endtask

  // Stop offering and let every outstanding result come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (gesture_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input tsc_pkg::reg_idx_t idx, input int val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val[15:0];
    case (idx)
      tsc_pkg::REG_SWIPE_MIN_DISTANCE: m_swipe_min = val[11:0];
      tsc_pkg::REG_TAP_MAX_MS:         m_tap_max   = val[15:0];
      tsc_pkg::REG_BRIGHTNESS_STEP:    m_step      = val[6:0];
      tsc_pkg::REG_BRIGHTNESS_MIN:     m_lo        = val[6:0];
      tsc_pkg::REG_BRIGHTNESS_MAX:     m_hi        = val[6:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic apply_config(input int thr, input int tap, input int step,
                              input int lo, input int hi);
    drain();
    write_reg(tsc_pkg::REG_SWIPE_MIN_DISTANCE, thr);
    write_reg(tsc_pkg::REG_TAP_MAX_MS, tap);
    write_reg(tsc_pkg::REG_BRIGHTNESS_STEP, step);
    write_reg(tsc_pkg::REG_BRIGHTNESS_MIN, lo);
    write_reg(tsc_pkg::REG_BRIGHTNESS_MAX, hi);
  endtask

  // Hand-picked cases under the reset configuration
  task automatic test_directed_gestures();
    poll_frame_t p;
    // failed read while the count says touched
    p = touch_at(1234, 567, 32'd100);
    p.read_ok = 1'b0;
    send_poll(p);
    // good read, zero count, junk in the upper status nibble
    p = touch_at(0, 0, 32'd100);
    p.status = 8'hF0;
    send_poll(p);
    // corner to corner: volume up, then swipe flag holds until next press
    send_poll(touch_at(0, 0, 32'd1000));
    send_poll(touch_at(COORD_MAX, 0, 32'd1010));
    send_poll(touch_at(0, COORD_MAX, 32'd1020));
    send_poll(lift_at(32'd1030));
    // volume down just past the threshold
    send_poll(touch_at(2000, 2000, 32'd2000));
    send_poll(touch_at(1949, 2000, 32'd2010));
    send_poll(lift_at(32'd2020));
    // upward swipe with brightness already at the top
    send_poll(touch_at(1000, 1000, 32'd3000));
    send_poll(touch_at(1000, 900, 32'd3010));
    send_poll(lift_at(32'd3020));
    // downward swipe
    send_poll(touch_at(1000, 1000, 32'd4000));
    send_poll(touch_at(1000, 1100, 32'd4010));
    send_poll(lift_at(32'd4020));
    // ratio test on the truncated 1.5 factor: equal is no swipe, one more is
    send_poll(touch_at(500, 500, 32'd5000));
    send_poll(touch_at(651, 601, 32'd5010));
    send_poll(touch_at(652, 601, 32'd5020));
    send_poll(lift_at(32'd5030));
    // travel equal to the threshold, then a tap one ms inside the limit
    send_poll(touch_at(100, 100, 32'd6000));
    send_poll(touch_at(150, 100, 32'd6010));
    send_poll(lift_at(32'd6499));
    // hold exactly the tap time: no tap
    send_poll(touch_at(7, 7, 32'd7000));
    send_poll(lift_at(32'd7500));
    // tap across the timestamp wrap
    send_poll(touch_at(COORD_MAX, COORD_MAX, 32'hFFFF_FF00));
    send_poll(lift_at(32'h0000_0010));
  endtask

  // Several register settings, the extremes and crossed clamp limits among them
  task automatic test_config_phases();
    int cfg_set[7][5] = '{
      '{0, 0, 0, 0, 0},
      '{4095, 65535, 100, 100, 100},
      '{20, 300, 100, 0, 100},
      '{30, 1000, 7, 80, 20},
      '{100, 65535, 1, 0, 100},
      '{5, 40, 33, 0, 0},
      '{50, 500, 10, 10, 100}
    };
    foreach (cfg_set[i]) begin
      apply_config(cfg_set[i][0], cfg_set[i][1], cfg_set[i][2], cfg_set[i][3],
                   cfg_set[i][4]);
      run_gestures(30);
    end
  endtask

  // Receiver holds off long enough for the block to stall its input
  task automatic test_output_stall();
    drain();
    tx_idle = 1'b0;
    hold_cycles = 300;
    run_gestures(40);
    tx_idle = 1'b1;
  endtask

  task automatic test_random_polls(input int n);
    int target;
    target = polls_sent + n;
    while (polls_sent < target) begin
      if ($urandom_range(0, 15) == 0) tx_idle = !tx_idle;
      if ($urandom_range(0, 15) == 0) rx_idle = !rx_idle;
      run_gestures(1);
    end
  endtask

  initial begin
    reset_model();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed_gestures();
    test_config_phases();
    test_output_stall();
    apply_config($urandom_range(10, 200), $urandom_range(100, 2000), $urandom_range(0, 100),
                 $urandom_range(0, 50), $urandom_range(50, 100));
    test_random_polls(230);
    // final stretch runs flat out on both sides
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    run_gestures(60);
    drain();
    repeat (10) @(posedge clk);
    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

  // Watchdog
  initial begin
    #2000000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule
